FILE: rtl/interval_range_attribute_table_macros.svh
// Assertion macros shared by the checker.
`ifndef INTERVAL_RANGE_ATTRIBUTE_TABLE_MACROS_SVH
`define INTERVAL_RANGE_ATTRIBUTE_TABLE_MACROS_SVH

// Same-cycle implication.
`define IRAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irat check failed");

// Next-cycle implication.
`define IRAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irat check failed");

`endif

FILE: rtl/irat_pkg.sv
`default_nettype none
package irat_pkg;
    localparam int DEPTH      = 32;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int M_BITS     = $clog2(DEPTH + 3);

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic FUNC_ASSIGN = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic start;
        logic eval;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic adv;
        logic done;
    } t_sts;
endpackage
`default_nettype wire

FILE: rtl/irat_if.sv
`default_nettype none
interface irat_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] range_begin;
    logic [31:0] range_end;
    logic [31:0] new_value;
    logic [31:0] query_key;
    modport source (output valid, func, range_begin, range_end, new_value, query_key,
                    input ready);
    modport sink (input valid, func, range_begin, range_end, new_value, query_key,
                  output ready);
endinterface

interface irat_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic [1:0]  status;
    modport source (output valid, read_value, status, input ready);
    modport sink (input valid, read_value, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/irat_ctrl.sv
`default_nettype none
module irat_ctrl
    import irat_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_RD, S_EVAL, S_FIN, S_OUT} t_state;
    t_state r_state;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.start   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.eval    = (r_state == S_EVAL);
    assign o_cmd.finish  = (r_state == S_FIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_RD;
                S_RD:   r_state <= S_EVAL;
                S_EVAL: begin
                    if (i_sts.done) r_state <= S_FIN;
                    else if (i_sts.adv) r_state <= S_RD;
                end
                S_FIN:  r_state <= S_OUT;
                S_OUT:  if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/irat_dp.sv
`default_nettype none
module irat_dp
    import irat_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [VALUE_BITS-1:0]  i_cfg_data,
    output logic [VALUE_BITS-1:0]  o_dflt,
    input  wire                    i_func,
    input  wire  [KEY_BITS-1:0]    i_begin,
    input  wire  [KEY_BITS-1:0]    i_end,
    input  wire  [VALUE_BITS-1:0]  i_value,
    input  wire  [KEY_BITS-1:0]    i_key,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic [VALUE_BITS-1:0]  o_read_value,
    output logic [1:0]             o_status
);
    typedef enum logic [1:0] {P_LOW, P_SKIP, P_HIGH} t_phase;

    // Two banks: rebuild goes into the idle bank, swapped only on success.
    logic [KEY_BITS+VALUE_BITS-1:0] r_mem [2*DEPTH];
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;

    logic                  r_bank;
    logic [CNT_BITS-1:0]   r_count;
    logic [VALUE_BITS-1:0] r_dflt;
    logic                  r_func;
    logic                  r_empty;
    logic [KEY_BITS-1:0]   r_b, r_e, r_q;
    logic [VALUE_BITS-1:0] r_v, r_prev, r_vend, r_res;
    logic [CNT_BITS-1:0]   r_i;
    logic [M_BITS-1:0]     r_m;
    t_phase                r_phase;
    logic [VALUE_BITS-1:0] r_out_val;
    logic [1:0]            r_out_sts;

    logic                  have;
    logic                  emit, adv, done;
    logic [KEY_BITS-1:0]   ek;
    logic [VALUE_BITS-1:0] ev;
    t_phase                n_phase;

    assign have = (r_i < r_count);

    always_comb begin
        emit    = 1'b0;
        adv     = 1'b0;
        done    = 1'b0;
        ek      = r_rd_key;
        ev      = r_rd_val;
        n_phase = r_phase;
        if (r_func == FUNC_LOOKUP) begin
            if (have && (r_rd_key <= r_q)) adv = 1'b1;
            else done = 1'b1;
        end else if (r_empty) begin
            done = 1'b1;
        end else begin
            case (r_phase)
                P_LOW: begin
                    emit = 1'b1;
                    if (have && (r_rd_key < r_b)) begin
                        adv = 1'b1;
                    end else begin
                        ek      = r_b;
                        ev      = r_v;
                        n_phase = P_SKIP;
                    end
                end
                P_SKIP: begin
                    if (have && (r_rd_key <= r_e)) begin
                        adv = 1'b1;
                    end else begin
                        emit    = 1'b1;
                        ek      = r_e;
                        ev      = r_vend;
                        n_phase = P_HIGH;
                    end
                end
                P_HIGH: begin
                    if (have) begin
                        emit = 1'b1;
                        adv  = 1'b1;
                    end else begin
                        done = 1'b1;
                    end
                end
                default: done = 1'b1;
            endcase
        end
    end

    assign o_sts.adv    = adv;
    assign o_sts.done   = done;
    assign o_dflt       = r_dflt;
    assign o_read_value = r_out_val;
    assign o_status     = r_out_sts;

    always_ff @(posedge i_clk) begin
        {r_rd_key, r_rd_val} <= r_mem[{r_bank, r_i[IDX_BITS-1:0]}];
        if (i_cmd.eval && emit && (ev != r_prev) && (r_m < M_BITS'(DEPTH))) begin
            r_mem[{~r_bank, r_m[IDX_BITS-1:0]}] <= {ek, ev};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_count <= '0;
            r_dflt  <= '0;
        end else begin
            if (i_cfg_we) r_dflt <= i_cfg_data;
            if (i_cmd.finish && (r_func == FUNC_ASSIGN) && !r_empty
                    && (r_m <= M_BITS'(DEPTH))) begin
                r_bank  <= ~r_bank;
                r_count <= CNT_BITS'(r_m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func  <= i_func;
            r_b     <= i_begin;
            r_e     <= i_end;
            r_v     <= i_value;
            r_q     <= i_key;
            r_empty <= (i_begin >= i_end);
            r_i     <= '0;
            r_m     <= '0;
            r_prev  <= r_dflt;
            r_vend  <= r_dflt;
            r_res   <= r_dflt;
            r_phase <= P_LOW;
        end
        if (i_cmd.eval) begin
            r_phase <= n_phase;
            if (adv) begin
                r_i <= r_i + CNT_BITS'(1);
                if (r_func == FUNC_LOOKUP) r_res <= r_rd_val;
                // value at the range end: last entry at or below it
                else if (r_phase != P_HIGH) r_vend <= r_rd_val;
            end
            // canonical form: drop an entry that repeats its predecessor's value
            if (emit && (ev != r_prev)) begin
                r_prev <= ev;
                r_m    <= r_m + M_BITS'(1);
            end
        end
        if (i_cmd.finish) begin
            if (r_func == FUNC_LOOKUP) begin
                r_out_val <= r_res;
                r_out_sts <= ST_DONE;
            end else begin
                r_out_val <= '0;
                if (r_empty) r_out_sts <= ST_EMPTY;
                else if (r_m > M_BITS'(DEPTH)) r_out_sts <= ST_FULL;
                else r_out_sts <= ST_DONE;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/interval_range_attribute_table.sv
// Sorted breakpoint table mapping keys to values, one transfer in and one result
// out at a time. The table holds up to 32 entries. A lookup walks it from entry
// 0 through every entry at or below the key; an assign streams every stored
// entry through the rebuild path into the spare bank of the table memory (one
// read per entry, registered). The single-port read of the table memory paces
// both walks. A full or empty assign leaves the table untouched. The default
// value register sits at byte address 0 of the APB port; writes are taken any
// time and must only be made while the block is idle.
`default_nettype none
module interval_range_attribute_table
    import irat_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    irat_in_if.sink     i_in,
    irat_out_if.source  o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cmd                  cmd;
    t_sts                  sts;
    logic [VALUE_BITS-1:0] dflt;
    logic                  cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? dflt : 32'd0;

    irat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    irat_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (pwdata),
        .o_dflt       (dflt),
        .i_func       (i_in.func),
        .i_begin      (i_in.range_begin),
        .i_end        (i_in.range_end),
        .i_value      (i_in.new_value),
        .i_key        (i_in.query_key),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_read_value (o_out.read_value),
        .o_status     (o_out.status)
    );
endmodule
`default_nettype wire

FILE: rtl/irat_checker.sv
`default_nettype none
`include "interval_range_attribute_table_macros.svh"
module irat_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_read_value,
    input wire [1:0]  i_status
);
    `IRAT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `IRAT_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `IRAT_ASSERT_NOW(a_one_at_a_time, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    `IRAT_ASSERT_NOW(a_assign_zero, i_clk, i_rst_n, i_out_valid && (i_status != 2'd0),
        i_read_value == 32'd0)
endmodule

bind interval_range_attribute_table irat_checker u_irat_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_read_value (o_out.read_value),
    .i_status     (o_out.status)
);
`default_nettype wire
